// File: hw/rtl/mka_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mka_pkg
// Shared types, constants and the printable-key check for the menu key
// auto-repeat block.
// ---------------------------------------------------------------------------
package mka_pkg;

   localparam int TICK_BITS = 16;
   localparam int CODE_BITS = 8;
   localparam int DELAY_BITS = 15;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CODE_BITS-1:0] UPSTROKE_MASK = 8'h80;
   localparam logic [CODE_BITS-1:0] NO_EVENT = 8'h00;

   typedef logic [TICK_BITS-1:0] tick_type;
   typedef logic [CODE_BITS-1:0] code_type;
   typedef logic [DELAY_BITS-1:0] delay_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MENU_CODE      = 4'd0,
      CSR_UP_CODE        = 4'd1,
      CSR_DOWN_CODE      = 4'd2,
      CSR_PAGE_UP_CODE   = 4'd3,
      CSR_PAGE_DOWN_CODE = 4'd4,
      CSR_BUTTON_HOLD    = 4'd5,
      CSR_REPEAT_START   = 4'd6,
      CSR_REPEAT_PERIOD  = 4'd7
   } csr_index_type;

   localparam delay_type BUTTON_HOLD_RESET   = 15'd1000;
   localparam delay_type REPEAT_START_RESET  = 15'd500;
   localparam delay_type REPEAT_PERIOD_RESET = 15'd100;

   typedef struct packed {
      code_type  menu_code;
      code_type  up_code;
      code_type  down_code;
      code_type  page_up_code;
      code_type  page_down_code;
      delay_type button_hold_ticks;
      delay_type repeat_start_ticks;
      delay_type repeat_period_ticks;
   } cfg_type;

   // letter and digit keys of the 7-bit scan code set
   function automatic logic is_printable(input logic [CODE_BITS-2:0] code);
      logic hit;
      hit = ((code >= 7'd1)  && (code <= 7'd10)) ||
            ((code >= 7'd16) && (code <= 7'd25)) ||
            ((code >= 7'd32) && (code <= 7'd40)) ||
            ((code >= 7'd49) && (code <= 7'd55));
      return hit;
   endfunction

   // deadline has passed when (deadline - now) has its top bit set
   function automatic logic expired(input tick_type deadline, input tick_type now);
      tick_type diff;
      diff = deadline - now;
      return diff[TICK_BITS-1];
   endfunction

endpackage : mka_pkg
`default_nettype wire

// File: hw/rtl/mka_csr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mka_csr
// Configuration register file: key codes and tick delays.
// ---------------------------------------------------------------------------
module mka_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [mka_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [mka_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output mka_pkg::cfg_type                     cfg
);
   import mka_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_ready = 1'b1;
   assign write = csr_valid;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_index_type'(csr_index))
            CSR_MENU_CODE:      cfg_in.menu_code = csr_data[CODE_BITS-1:0];
            CSR_UP_CODE:        cfg_in.up_code = csr_data[CODE_BITS-1:0];
            CSR_DOWN_CODE:      cfg_in.down_code = csr_data[CODE_BITS-1:0];
            CSR_PAGE_UP_CODE:   cfg_in.page_up_code = csr_data[CODE_BITS-1:0];
            CSR_PAGE_DOWN_CODE: cfg_in.page_down_code = csr_data[CODE_BITS-1:0];
            CSR_BUTTON_HOLD:    cfg_in.button_hold_ticks = csr_data[DELAY_BITS-1:0];
            CSR_REPEAT_START:   cfg_in.repeat_start_ticks = csr_data[DELAY_BITS-1:0];
            CSR_REPEAT_PERIOD:  cfg_in.repeat_period_ticks = csr_data[DELAY_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.menu_code           <= '0;
         cfg_ff.up_code             <= '0;
         cfg_ff.down_code           <= '0;
         cfg_ff.page_up_code        <= '0;
         cfg_ff.page_down_code      <= '0;
         cfg_ff.button_hold_ticks   <= BUTTON_HOLD_RESET;
         cfg_ff.repeat_start_ticks  <= REPEAT_START_RESET;
         cfg_ff.repeat_period_ticks <= REPEAT_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule : mka_csr
`default_nettype wire

// File: hw/rtl/mka_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mka_step
// Per-poll event logic: button substitution, change detect, repeat timers.
// State advances once per request that leaves the input register.
// ---------------------------------------------------------------------------
module mka_step (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  advance,
   input  mka_pkg::cfg_type                     cfg,
   input  wire  [mka_pkg::CODE_BITS-1:0]        key_code,
   input  wire                                  button_held,
   input  wire  [mka_pkg::TICK_BITS-1:0]        now_ticks,
   output logic [mka_pkg::CODE_BITS-1:0]        key_event
);
   import mka_pkg::*;

   code_type last_code_ff, last_code_in;
   tick_type button_deadline_ff, button_deadline_in;
   tick_type repeat_deadline_ff, repeat_deadline_in;
   logic     slow_phase_ff, slow_phase_in;

   logic     button_expired;
   logic     repeat_expired;
   code_type code;
   logic     upstroke;
   logic     fast_key;
   logic     slow_key;
   logic     fire;

   always_comb begin
      button_expired = expired(button_deadline_ff, now_ticks);
      repeat_expired = expired(repeat_deadline_ff, now_ticks);

      code = key_code;
      button_deadline_in = button_deadline_ff;
      if (!button_held) begin
         button_deadline_in = now_ticks + TICK_BITS'(cfg.button_hold_ticks);
      end else if (button_expired) begin
         code = cfg.menu_code;
         // keeps the substitution alive while the button stays down
         button_deadline_in = now_ticks - TICK_BITS'(1);
      end

      last_code_in = code;
      upstroke = (code & UPSTROKE_MASK) != '0;
      fast_key = (code == cfg.up_code) || (code == cfg.down_code);
      slow_key = (code == cfg.page_up_code) || (code == cfg.page_down_code) ||
                 is_printable(code[CODE_BITS-2:0]);

      fire = (code != last_code_ff);
      repeat_deadline_in = repeat_deadline_ff;
      slow_phase_in = slow_phase_ff;
      if (upstroke) begin
         repeat_deadline_in = now_ticks + TICK_BITS'(cfg.repeat_start_ticks);
      end else if (repeat_expired) begin
         repeat_deadline_in = now_ticks + TICK_BITS'(cfg.repeat_period_ticks);
         slow_phase_in = !slow_phase_ff;
         if (fast_key || (slow_phase_ff && slow_key)) begin
            fire = 1'b1;
         end
      end

      key_event = fire ? code : NO_EVENT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_code_ff       <= '0;
         button_deadline_ff <= '0;
         repeat_deadline_ff <= '0;
         slow_phase_ff      <= 1'b0;
      end else if (advance) begin
         last_code_ff       <= last_code_in;
         button_deadline_ff <= button_deadline_in;
         repeat_deadline_ff <= repeat_deadline_in;
         slow_phase_ff      <= slow_phase_in;
      end
   end

endmodule : mka_step
`default_nettype wire

// File: hw/rtl/menu_key_autorepeat.sv
`default_nettype none
// ---------------------------------------------------------------------------
// menu_key_autorepeat
// Key event generator with front-button menu substitution and typematic
// auto-repeat.
// ---------------------------------------------------------------------------
//  channel  ports                                        direction
//  req      req_valid/ready, key_code, button_held,      in
//           now_ticks
//  rsp      rsp_valid/ready, key_event                   out
//  csr      csr_valid/ready, csr_index, csr_data         in
//
//  One request per cycle sustained while rsp is not stalled; an accepted
//  request passes the input register, then the response register.
//  Reset is synchronous; it clears the pipeline valids, event state and
//  loads the register defaults. A stalled response holds the pipeline; the
//  input register still takes a request while it is empty.
//  csr_ready is always high; indexes past the register list are ignored.
// ---------------------------------------------------------------------------
module menu_key_autorepeat (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [7:0]                           req_key_code,
   input  wire                                  req_button_held,
   input  wire  [15:0]                          req_now_ticks,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [7:0]                           rsp_key_event,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [mka_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [mka_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import mka_pkg::*;

   cfg_type  cfg;

   logic     req_valid_ff;
   code_type req_key_code_ff;
   logic     req_button_held_ff;
   tick_type req_now_ticks_ff;

   logic     rsp_valid_ff, rsp_valid_in;
   code_type rsp_key_event_ff;
   code_type key_event;

   logic     out_free;
   logic     advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_key_event = rsp_key_event_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   mka_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mka_step u_step (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cfg         (cfg),
      .key_code    (req_key_code_ff),
      .button_held (req_button_held_ff),
      .now_ticks   (req_now_ticks_ff),
      .key_event   (key_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_key_code_ff    <= req_key_code;
         req_button_held_ff <= req_button_held;
         req_now_ticks_ff   <= req_now_ticks[TICK_BITS-1:0];
      end
      if (advance) begin
         rsp_key_event_ff <= key_event;
      end
   end

endmodule : menu_key_autorepeat
`default_nettype wire

// File: tb/sv/menu_key_autorepeat_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// menu_key_autorepeat_checker
// Passive checker for the menu key auto-repeat block. It follows register
// writes, predicts the key event of every accepted request from its own
// copy of the key, button and repeat state, and compares each response in
// order against the oldest prediction.
// ---------------------------------------------------------------------------
module menu_key_autorepeat_checker
   import mka_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire                       req_ready,
   input  wire  [CODE_BITS-1:0]      req_key_code,
   input  wire                       req_button_held,
   input  wire  [TICK_BITS-1:0]      req_now_ticks,
   input  wire                       rsp_valid,
   input  wire                       rsp_ready,
   input  wire  [CODE_BITS-1:0]      rsp_key_event,
   input  wire                       csr_valid,
   input  wire                       csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [CSR_DATA_BITS-1:0]  csr_data,
   output int                        fail_count,
   output int                        pending_count,
   output int                        checked_count,
   output int                        event_count,
   output int                        repeat_count,
   output int                        menu_count
);

   localparam int REPORT_LIMIT = 10;
   // letter and digit keys, indexed by the low seven bits of a code
   localparam logic [127:0] LETTER_DIGIT_KEYS = 128'h00FE_01FF_03FF_07FE;

   cfg_type  regs;
   code_type last_key;
   tick_type hold_deadline;
   tick_type repeat_deadline;
   logic     slow_phase;
   code_type expected_events[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      event_count   = 0;
      repeat_count  = 0;
      menu_count    = 0;
   end

   function automatic logic deadline_passed(input tick_type deadline, input tick_type now);
      tick_type gap;
      gap = deadline - now;
      return gap[TICK_BITS-1];
   endfunction

   function automatic code_type predict_key_event(input code_type key, input logic held,
                                                  input tick_type now);
      code_type code;
      code_type key_event;
      code      = key;
      key_event = NO_EVENT;

      if (!held) begin
         hold_deadline = now + tick_type'(regs.button_hold_ticks);
      end else if (deadline_passed(hold_deadline, now)) begin
         // deadline parked one tick behind so the menu code sticks while held
         code          = regs.menu_code;
         hold_deadline = now - tick_type'(1);
         menu_count++;
      end

      if (code != last_key) key_event = code;
      last_key = code;

      if ((code & UPSTROKE_MASK) != '0) begin
         repeat_deadline = now + tick_type'(regs.repeat_start_ticks);
      end else if (deadline_passed(repeat_deadline, now)) begin
         repeat_deadline = now + tick_type'(regs.repeat_period_ticks);
         repeat_count++;
         if (code == regs.up_code || code == regs.down_code) key_event = code;
         // slow keys fire on every second expiry
         if (slow_phase) begin
            slow_phase = 1'b0;
            if (code == regs.page_up_code || code == regs.page_down_code ||
                LETTER_DIGIT_KEYS[code[CODE_BITS-2:0]])
               key_event = code;
         end else begin
            slow_phase = 1'b1;
         end
      end
      return key_event;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      code_type expected;
      if (reset) begin
         regs                     = '0;
         regs.button_hold_ticks   = BUTTON_HOLD_RESET;
         regs.repeat_start_ticks  = REPEAT_START_RESET;
         regs.repeat_period_ticks = REPEAT_PERIOD_RESET;
         last_key                 = '0;
         hold_deadline            = '0;
         repeat_deadline          = '0;
         slow_phase               = 1'b0;
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MENU_CODE:      regs.menu_code           = csr_data[CODE_BITS-1:0];
               CSR_UP_CODE:        regs.up_code             = csr_data[CODE_BITS-1:0];
               CSR_DOWN_CODE:      regs.down_code           = csr_data[CODE_BITS-1:0];
               CSR_PAGE_UP_CODE:   regs.page_up_code        = csr_data[CODE_BITS-1:0];
               CSR_PAGE_DOWN_CODE: regs.page_down_code      = csr_data[CODE_BITS-1:0];
               CSR_BUTTON_HOLD:    regs.button_hold_ticks   = csr_data[DELAY_BITS-1:0];
               CSR_REPEAT_START:   regs.repeat_start_ticks  = csr_data[DELAY_BITS-1:0];
               CSR_REPEAT_PERIOD:  regs.repeat_period_ticks = csr_data[DELAY_BITS-1:0];
               default: ;
            endcase
         end

         // compare before queuing so a same-edge request cannot cover a stray response
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               note_failure($sformatf("response %02h with no request outstanding",
                                      rsp_key_event));
            end else begin
               expected = expected_events.pop_front();
               if (rsp_key_event !== expected)
                  note_failure($sformatf("key_event mismatch on request %0d: expected %02h got %02h",
                                         checked_count, expected, rsp_key_event));
               checked_count++;
               if (expected != NO_EVENT) event_count++;
            end
         end

         if (req_valid && req_ready)
            expected_events.push_back(predict_key_event(req_key_code, req_button_held,
                                                        req_now_ticks));
      end
      pending_count = expected_events.size();
   end

endmodule : menu_key_autorepeat_checker
`default_nettype wire

// File: tb/sv/menu_key_autorepeat_test.sv
`default_nettype none
// ---------------------------------------------------------------------------
// menu_key_autorepeat_test
// Testbench top for the menu key auto-repeat block. Runs a short directed
// sequence, then held-key and held-button sessions with random codes and
// tick steps under eight register settings, with random gaps on both
// channels, one stretch without gaps and one long response stall.
// ---------------------------------------------------------------------------
module menu_key_autorepeat_test;
   import mka_pkg::*;

   localparam int IDLE_PERCENT    = 34;
   localparam int PHASES          = 8;
   localparam int STEADY_PHASE    = 3;
   localparam int ITEMS_PER_PHASE = 122;
   localparam int PRESSURE_AT     = 600;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 4;   // two register stages plus margin
   localparam int CYCLE_LIMIT     = 200000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 4'd11;

   localparam cfg_type DIRECTED_CFG = '{
      menu_code:           8'h3A,
      up_code:             8'h48,
      down_code:           8'h50,
      page_up_code:        8'h49,
      page_down_code:      8'h51,
      button_hold_ticks:   15'd40,
      repeat_start_ticks:  15'd30,
      repeat_period_ticks: 15'd10
   };

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_ready;
   code_type                  req_key_code    = '0;
   logic                      req_button_held = 1'b0;
   tick_type                  req_now_ticks   = '0;
   logic                      rsp_valid;
   logic                      rsp_ready       = 1'b0;
   code_type                  rsp_key_event;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index       = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data        = '0;

   int fail_count;
   int pending_count;
   int checked_count;
   int event_count;
   int repeat_count;
   int menu_count;

   int       requests_sent   = 0;
   int       settings_loaded = 0;
   bit       no_idle         = 1'b0;
   tick_type poll_time       = '0;
   cfg_type  cfg_now         = DIRECTED_CFG;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   menu_key_autorepeat u_top (.*);

   menu_key_autorepeat_checker u_checker (.*);

   task automatic send_req(input code_type key, input logic held, input tick_type now);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_key_code    <= key;
      req_button_held <= held;
      req_now_ticks   <= now;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // upper data bits are junk on purpose, the block must drop them
   task automatic load_config(input cfg_type c);
      wait_drained();
      write_csr(CSR_MENU_CODE,      {8'($urandom), c.menu_code});
      write_csr(CSR_UP_CODE,        {8'($urandom), c.up_code});
      write_csr(CSR_DOWN_CODE,      {8'($urandom), c.down_code});
      write_csr(CSR_PAGE_UP_CODE,   {8'($urandom), c.page_up_code});
      write_csr(CSR_PAGE_DOWN_CODE, {8'($urandom), c.page_down_code});
      write_csr(CSR_BUTTON_HOLD,    {1'($urandom), c.button_hold_ticks});
      write_csr(CSR_REPEAT_START,   {1'($urandom), c.repeat_start_ticks});
      write_csr(CSR_REPEAT_PERIOD,  {1'($urandom), c.repeat_period_ticks});
      write_csr(CSR_SPARE_INDEX,    16'($urandom));
      csr_valid <= 1'b0;
      cfg_now = c;
      settings_loaded++;
   endtask

   function automatic cfg_type phase_config(input int phase);
      cfg_type c;
      c.menu_code           = code_type'($urandom_range(0, 127));
      c.up_code             = code_type'($urandom_range(0, 127));
      c.down_code           = code_type'($urandom_range(0, 127));
      c.page_up_code        = code_type'($urandom_range(0, 127));
      c.page_down_code      = code_type'($urandom_range(0, 127));
      c.button_hold_ticks   = delay_type'($urandom_range(0, 80));
      c.repeat_start_ticks  = delay_type'($urandom_range(0, 60));
      c.repeat_period_ticks = delay_type'($urandom_range(1, 30));
      case (phase)
         1: begin
            c.menu_code           = 8'hFF;
            c.up_code             = 8'h00;
            c.down_code           = 8'hFF;
            c.page_up_code        = 8'h00;
            c.page_down_code      = 8'h7F;
            c.button_hold_ticks   = '0;
            c.repeat_start_ticks  = '0;
            c.repeat_period_ticks = '0;
         end
         2: begin
            c.button_hold_ticks   = '1;
            c.repeat_start_ticks  = '1;
            c.repeat_period_ticks = '1;
         end
         4: begin
            c.button_hold_ticks   = '0;
            c.repeat_start_ticks  = '1;
            c.repeat_period_ticks = delay_type'(1);
         end
         5: begin
            c.button_hold_ticks   = delay_type'($urandom_range(0, 32767));
            c.repeat_start_ticks  = delay_type'($urandom_range(0, 32767));
            c.repeat_period_ticks = delay_type'($urandom_range(0, 32767));
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic code_type pick_key();
      case ($urandom_range(0, 9))
         0:       return cfg_now.up_code;
         1:       return cfg_now.down_code;
         2:       return cfg_now.page_up_code;
         3:       return cfg_now.page_down_code;
         4:       return cfg_now.menu_code;
         5:       return code_type'($urandom_range(1, 55));
         6:       return code_type'($urandom_range(0, 127));
         7:       return code_type'($urandom_range(0, 255));
         8:       return code_type'($urandom_range(128, 255));
         default: return NO_EVENT;
      endcase
   endfunction

   // steps scaled to the current delays so deadlines are reached and crossed
   function automatic tick_type pick_step();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 3)  return '0;
      if (pick == 3) return tick_type'($urandom);
      if (pick < 12) return tick_type'($urandom_range(0, cfg_now.repeat_period_ticks / 2 + 1));
      if (pick < 16) return tick_type'($urandom_range(0, cfg_now.repeat_start_ticks / 4 + 1));
      return tick_type'($urandom_range(0, cfg_now.button_hold_ticks / 4 + 1));
   endfunction

   // one key held over several polls, a little noise, sometimes an upstroke after
   task automatic run_session();
      code_type key;
      code_type poll_key;
      logic     held;
      logic     poll_held;
      int       polls;
      key   = pick_key();
      held  = ($urandom_range(0, 3) == 0);
      polls = $urandom_range(1, 16);
      for (int i = 0; i < polls; i++) begin
         poll_key  = ($urandom_range(0, 9) == 0) ? code_type'($urandom) : key;
         poll_held = ($urandom_range(0, 9) == 0) ? !held : held;
         poll_time += pick_step();
         send_req(poll_key, poll_held, poll_time);
      end
      if ($urandom_range(0, 1) == 0) begin
         poll_time += pick_step();
         send_req(key | UPSTROKE_MASK, held, poll_time);
      end
   endtask

   initial begin : response_sink
      bit held_off;
      held_off = 1'b0;
      @(posedge clock);
      forever begin
         if (!reset && !held_off && requests_sent >= PRESSURE_AT) begin
            // long stall while requests keep coming, fills the pipeline
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycles_run;
      cycles_run = 0;
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int phase_start;
      do @(posedge clock); while (reset);

      // register defaults: all special codes zero, menu substitution gives no event
      send_req(8'h00, 1'b0, 16'h0000);
      send_req(8'hFF, 1'b0, 16'hFFFF);
      send_req(8'h7F, 1'b1, 16'h0005);
      send_req(8'h7F, 1'b1, 16'h8004);
      send_req(8'h01, 1'b1, 16'h8005);
      send_req(8'h01, 1'b0, 16'h8006);
      send_req(8'h81, 1'b0, 16'h8007);

      load_config(DIRECTED_CFG);
      // cursor up repeats every period
      send_req(8'h48, 1'b0, 16'h0100);
      send_req(8'h48, 1'b0, 16'h0140);
      send_req(8'h48, 1'b0, 16'h014A);
      send_req(8'h48, 1'b0, 16'h0154);
      send_req(8'hC8, 1'b0, 16'h0156);
      // letter key repeats every second period
      send_req(8'h10, 1'b0, 16'h0160);
      send_req(8'h10, 1'b0, 16'h0180);
      send_req(8'h10, 1'b0, 16'h018A);
      send_req(8'h10, 1'b0, 16'h0194);
      send_req(8'h49, 1'b0, 16'h01A0);
      send_req(8'h49, 1'b0, 16'h01C0);
      send_req(8'h49, 1'b0, 16'h01CA);
      send_req(8'h49, 1'b0, 16'h01D4);
      // button held past its deadline, then released
      send_req(8'h20, 1'b1, 16'h0200);
      send_req(8'h20, 1'b1, 16'h0230);
      send_req(8'h20, 1'b1, 16'h0240);
      send_req(8'h20, 1'b0, 16'h0250);
      send_req(8'h00, 1'b0, 16'h0260);

      poll_time = 16'h0300;
      for (int phase = 0; phase < PHASES; phase++) begin
         load_config(phase_config(phase));
         no_idle     = (phase == STEADY_PHASE);
         phase_start = requests_sent;
         while (requests_sent - phase_start < ITEMS_PER_PHASE) run_session();
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses over %0d register settings, one long response stall",
               checked_count, settings_loaded);
      $display("%0d key events, %0d repeat expiries, %0d menu substitutions",
               event_count, repeat_count, menu_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule : menu_key_autorepeat_test
`default_nettype wire
